/* rtl/lie_pkg.sv */
// ----------------------------------------------------------------------------
// lie_pkg
// shared constants, status codes and controller/datapath interface structs
// ----------------------------------------------------------------------------
package lie_pkg;

    localparam int MAX_POINTS = 16;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);

    // result status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_AXES = 2'd1;
    localparam logic [1:0] ST_DUP  = 2'd2;
    localparam logic [1:0] ST_SAT  = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_DOMAIN   = 2'd0;
    localparam logic [1:0] CFG_CODOMAIN = 2'd1;
    localparam logic [1:0] CFG_COUNT    = 2'd2;

    // axis codes
    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;

    // divider: 33-bit magnitude shifted by 16 fraction bits
    localparam int DIV_N_W = 49;
    localparam int DIV_D_W = 33;

    typedef struct packed {
        logic             wr;
        logic             load_q;
        logic             pend_set;
        logic [1:0]       pend_status;
        logic             rd;
        logic [IDX_W-1:0] addr_i;
        logic [IDX_W-1:0] addr_j;
        logic             div_start;
        logic             fclamp;
        logic             mul;
        logic             mul_term;
        logic             li_init;
        logic             li_upd;
        logic             acc;
        logic             fin;
        logic             out_load;
    } cmd_t;

    typedef struct packed {
        logic             axes_eq;
        logic             dup_eq;
        logic             div_done;
        logic [CNT_W-1:0] count;
    } sts_t;

    // pick one coordinate out of a stored {z, y, x} word, code three means z
    function automatic logic signed [31:0] sel_axis(input logic [95:0] w,
                                                    input logic [1:0] axis);
        logic signed [31:0] r;
        case (axis)
            AXIS_X:  r = w[31:0];
            AXIS_Y:  r = w[63:32];
            default: r = w[95:64];
        endcase
        return r;
    endfunction

    // drop 16 fraction bits, rounding toward zero
    function automatic logic signed [63:0] trunc16(input logic signed [63:0] p);
        logic signed [63:0] adj;
        adj = p + (p[63] ? 64'sd65535 : 64'sd0);
        return adj >>> 16;
    endfunction

endpackage

/* rtl/lagrange_interpolation_eval.sv */
// ----------------------------------------------------------------------------
// lagrange_interpolation_eval
// Q16.16 lagrange interpolation over up to sixteen stored 3d points
// ----------------------------------------------------------------------------
//  channel  handshake             payload
//  in       in_valid / in_stall   mode, point_index, coord_x/y/z, query
//  out      out_valid / out_stall value, status
//  cfg      cfg_we                cfg_index, cfg_data
//
//  an evaluate of n points first scans every pair for duplicate abscissas,
//  then builds the basis products with the serial 49-step divider shared by
//  every basis factor, and accumulates the terms
//  reset returns control and configuration to defaults; point memory is undefined until written
//  in_stall is high while a transaction is in work; a finished result sits in
//  the output register, so the next input is taken while out_stall holds it
// ----------------------------------------------------------------------------
module lagrange_interpolation_eval
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_index,
    input  logic [4:0]            cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  mode,
    input  logic [3:0]            point_index,
    input  logic signed [31:0]    coord_x,
    input  logic signed [31:0]    coord_y,
    input  logic signed [31:0]    coord_z,
    input  logic signed [31:0]    query,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic signed [31:0]    value,
    output logic [1:0]            status
);
    import lie_pkg::*;

    cmd_t cmd;
    sts_t sts;

    lie_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .mode      (mode),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    lie_dp u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .point_index (point_index[IDX_W-1:0]),
        .coord_x     (coord_x),
        .coord_y     (coord_y),
        .coord_z     (coord_z),
        .query       (query),
        .cmd         (cmd),
        .sts         (sts),
        .value       (value),
        .status      (status)
    );

    // error results carry a zero value
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_AXES || status == ST_DUP) |-> value == 32'sd0)
        else $error("error result with nonzero value");

    // an accepted transaction keeps the input side busy next cycle
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input not held off after accept");

    // a new result only appears after work on a transaction
    a_res_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result without transaction");

endmodule

/* rtl/lie_dp.sv */
// ----------------------------------------------------------------------------
// lie_dp
// point memory, configuration, serial divider, multiplier and accumulator
// ----------------------------------------------------------------------------
module lie_dp
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_index,
    input  logic [4:0]            cfg_data,
    input  logic [lie_pkg::IDX_W-1:0] point_index,
    input  logic signed [31:0]    coord_x,
    input  logic signed [31:0]    coord_y,
    input  logic signed [31:0]    coord_z,
    input  logic signed [31:0]    query,
    input  lie_pkg::cmd_t         cmd,
    output lie_pkg::sts_t         sts,
    output logic signed [31:0]    value,
    output logic [1:0]            status
);
    import lie_pkg::*;

    logic [1:0]  dom_reg;
    logic [1:0]  cod_reg;
    logic [4:0]  cnt_reg;

    logic [95:0] pt_mem [MAX_POINTS];
    logic [95:0] rd_a_reg;
    logic [95:0] rd_b_reg;

    logic signed [31:0] q_reg;
    logic signed [31:0] f_reg;
    logic signed [31:0] li_reg;
    logic signed [63:0] prod_reg;
    logic signed [63:0] sum_reg;
    logic               sat_reg;

    logic [DIV_N_W-1:0] dq_reg;
    logic [DIV_D_W-1:0] drem_reg;
    logic [DIV_D_W-1:0] dden_reg;
    logic [5:0]         dcnt_reg;
    logic               dneg_reg;

    logic signed [31:0] pend_value_reg;
    logic [1:0]         pend_status_reg;
    logic signed [31:0] value_reg;
    logic [1:0]         status_reg;

    logic [1:0]         dom_m;
    logic [1:0]         cod_m;
    logic signed [31:0] xi;
    logic signed [31:0] xj;
    logic signed [31:0] yi;
    logic signed [32:0] num_d;
    logic signed [32:0] den_d;
    logic [32:0]        num_mag;
    logic [32:0]        den_mag;
    logic [DIV_D_W:0]   rem_sh;
    logic [DIV_D_W:0]   rem_sub;
    logic signed [31:0] f_next;
    logic               f_sat;
    logic signed [63:0] tq;
    logic signed [31:0] li_next;
    logic               li_sat;
    logic signed [31:0] fin_value;
    logic               fin_sat;
    logic signed [31:0] mul_a;
    logic signed [31:0] mul_b;

    // axis code three behaves as z
    assign dom_m = (dom_reg == 2'd3) ? 2'd2 : dom_reg;
    assign cod_m = (cod_reg == 2'd3) ? 2'd2 : cod_reg;

    assign xi = sel_axis(rd_a_reg, dom_m);
    assign xj = sel_axis(rd_b_reg, dom_m);
    assign yi = sel_axis(rd_a_reg, cod_m);

    assign sts.axes_eq  = (dom_m == cod_m);
    assign sts.dup_eq   = (xi == xj);
    assign sts.div_done = (dcnt_reg == 6'd0);
    assign sts.count    = (cnt_reg > 5'(MAX_POINTS)) ? CNT_W'(MAX_POINTS) : CNT_W'(cnt_reg);

    assign num_d   = 33'(q_reg) - 33'(xj);
    assign den_d   = 33'(xi) - 33'(xj);
    assign num_mag = num_d[32] ? 33'(-num_d) : 33'(num_d);
    assign den_mag = den_d[32] ? 33'(-den_d) : 33'(den_d);

    assign rem_sh  = {drem_reg, dq_reg[DIV_N_W-1]};
    assign rem_sub = rem_sh - {1'b0, dden_reg};

    // quotient magnitude to signed 32 with clamp
    always_comb
    begin
        f_sat  = 1'b0;
        f_next = 32'(dq_reg);
        if (dneg_reg)
        begin
            if (dq_reg > DIV_N_W'(64'h8000_0000))
            begin
                f_sat  = 1'b1;
                f_next = 32'sh8000_0000;
            end
            else
            begin
                f_next = 32'(-dq_reg);
            end
        end
        else if (dq_reg > DIV_N_W'(64'h7fff_ffff))
        begin
            f_sat  = 1'b1;
            f_next = 32'sh7fff_ffff;
        end
    end

    assign tq = trunc16(prod_reg);

    always_comb
    begin
        li_sat  = 1'b0;
        li_next = tq[31:0];
        if (tq > 64'sh7fff_ffff)
        begin
            li_sat  = 1'b1;
            li_next = 32'sh7fff_ffff;
        end
        else if (tq < -64'sh8000_0000)
        begin
            li_sat  = 1'b1;
            li_next = 32'sh8000_0000;
        end
    end

    always_comb
    begin
        fin_sat   = 1'b0;
        fin_value = sum_reg[31:0];
        if (sum_reg > 64'sh7fff_ffff)
        begin
            fin_sat   = 1'b1;
            fin_value = 32'sh7fff_ffff;
        end
        else if (sum_reg < -64'sh8000_0000)
        begin
            fin_sat   = 1'b1;
            fin_value = 32'sh8000_0000;
        end
    end

    assign mul_a = cmd.mul_term ? yi : li_reg;
    assign mul_b = cmd.mul_term ? li_reg : f_reg;

    // point memory
    always_ff @(posedge clk)
    begin
        if (cmd.wr)
            pt_mem[point_index] <= {coord_z, coord_y, coord_x};
        if (cmd.rd)
        begin
            rd_a_reg <= pt_mem[cmd.addr_i];
            rd_b_reg <= pt_mem[cmd.addr_j];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dom_reg  <= 2'd0;
            cod_reg  <= 2'd1;
            cnt_reg  <= 5'd1;
            dcnt_reg <= 6'd0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_DOMAIN:   dom_reg <= cfg_data[1:0];
                    CFG_CODOMAIN: cod_reg <= cfg_data[1:0];
                    CFG_COUNT:    cnt_reg <= cfg_data;
                    default:      ;
                endcase
            end
            if (cmd.div_start)
                dcnt_reg <= 6'(DIV_N_W);
            else if (dcnt_reg != 6'd0)
                dcnt_reg <= dcnt_reg - 6'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_q)
        begin
            q_reg   <= query;
            sum_reg <= 64'sd0;
            sat_reg <= 1'b0;
        end
        // restoring divide, one quotient bit per cycle
        if (cmd.div_start)
        begin
            dq_reg   <= {num_mag, 16'd0};
            drem_reg <= '0;
            dden_reg <= den_mag;
            dneg_reg <= num_d[32] ^ den_d[32];
        end
        else if (dcnt_reg != 6'd0)
        begin
            if (!rem_sub[DIV_D_W])
            begin
                drem_reg <= rem_sub[DIV_D_W-1:0];
                dq_reg   <= {dq_reg[DIV_N_W-2:0], 1'b1};
            end
            else
            begin
                drem_reg <= rem_sh[DIV_D_W-1:0];
                dq_reg   <= {dq_reg[DIV_N_W-2:0], 1'b0};
            end
        end
        if (cmd.fclamp)
        begin
            f_reg <= f_next;
            if (f_sat)
                sat_reg <= 1'b1;
        end
        if (cmd.mul)
            prod_reg <= mul_a * mul_b;
        if (cmd.li_init)
            li_reg <= 32'sd65536;
        else if (cmd.li_upd)
        begin
            li_reg <= li_next;
            if (li_sat)
                sat_reg <= 1'b1;
        end
        if (cmd.acc)
            sum_reg <= sum_reg + tq;
        if (cmd.pend_set)
        begin
            pend_value_reg  <= 32'sd0;
            pend_status_reg <= cmd.pend_status;
        end
        else if (cmd.fin)
        begin
            pend_value_reg  <= fin_value;
            pend_status_reg <= (sat_reg || fin_sat) ? ST_SAT : ST_OK;
        end
        if (cmd.out_load)
        begin
            value_reg  <= pend_value_reg;
            status_reg <= pend_status_reg;
        end
    end

    assign value  = value_reg;
    assign status = status_reg;

endmodule

/* rtl/lie_ctrl.sv */
// ----------------------------------------------------------------------------
// lie_ctrl
// sequencer: duplicate scan, basis products, term accumulation, handshakes
// ----------------------------------------------------------------------------
module lie_ctrl
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic          mode,
    output logic          in_stall,
    output logic          out_valid,
    input  logic          out_stall,
    input  lie_pkg::sts_t sts,
    output lie_pkg::cmd_t cmd
);
    import lie_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DRD   = 4'd1;
    localparam logic [3:0] S_DCMP  = 4'd2;
    localparam logic [3:0] S_EI    = 4'd3;
    localparam logic [3:0] S_EJ    = 4'd4;
    localparam logic [3:0] S_ERD   = 4'd5;
    localparam logic [3:0] S_EDIV0 = 4'd6;
    localparam logic [3:0] S_EDIV  = 4'd7;
    localparam logic [3:0] S_EFCL  = 4'd8;
    localparam logic [3:0] S_EMUL  = 4'd9;
    localparam logic [3:0] S_ELI   = 4'd10;
    localparam logic [3:0] S_TRD   = 4'd11;
    localparam logic [3:0] S_TMUL  = 4'd12;
    localparam logic [3:0] S_TACC  = 4'd13;
    localparam logic [3:0] S_FIN   = 4'd14;
    localparam logic [3:0] S_DONE  = 4'd15;

    logic [3:0]       state_reg, state_next;
    logic [CNT_W-1:0] i_reg, i_next;
    logic [CNT_W-1:0] j_reg, j_next;
    logic             out_valid_reg, out_valid_next;

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        cmd        = '0;
        cmd.addr_i = i_reg[IDX_W-1:0];
        cmd.addr_j = j_reg[IDX_W-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (!mode)
                    begin
                        cmd.wr          = 1'b1;
                        cmd.pend_set    = 1'b1;
                        cmd.pend_status = ST_OK;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        cmd.load_q = 1'b1;
                        i_next     = '0;
                        j_next     = CNT_W'(1);
                        if (sts.axes_eq)
                        begin
                            cmd.pend_set    = 1'b1;
                            cmd.pend_status = ST_AXES;
                            state_next      = S_DONE;
                        end
                        else if (sts.count == '0)
                        begin
                            cmd.pend_set    = 1'b1;
                            cmd.pend_status = ST_OK;
                            state_next      = S_DONE;
                        end
                        else if (sts.count == CNT_W'(1))
                            state_next = S_EI;
                        else
                            state_next = S_DRD;
                    end
                end
            end
            S_DRD:
            begin
                cmd.rd     = 1'b1;
                state_next = S_DCMP;
            end
            S_DCMP:
            begin
                if (sts.dup_eq)
                begin
                    cmd.pend_set    = 1'b1;
                    cmd.pend_status = ST_DUP;
                    state_next      = S_DONE;
                end
                else if (j_reg + CNT_W'(1) < sts.count)
                begin
                    j_next     = j_reg + CNT_W'(1);
                    state_next = S_DRD;
                end
                else if (i_reg + CNT_W'(2) < sts.count)
                begin
                    i_next     = i_reg + CNT_W'(1);
                    j_next     = i_reg + CNT_W'(2);
                    state_next = S_DRD;
                end
                else
                begin
                    i_next     = '0;
                    state_next = S_EI;
                end
            end
            S_EI:
            begin
                cmd.li_init = 1'b1;
                j_next      = '0;
                state_next  = S_EJ;
            end
            S_EJ:
            begin
                if (j_reg >= sts.count)
                    state_next = S_TRD;
                else if (j_reg == i_reg)
                    j_next = j_reg + CNT_W'(1);
                else
                    state_next = S_ERD;
            end
            S_ERD:
            begin
                cmd.rd     = 1'b1;
                state_next = S_EDIV0;
            end
            S_EDIV0:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_EDIV;
            end
            S_EDIV:
            begin
                if (sts.div_done)
                    state_next = S_EFCL;
            end
            S_EFCL:
            begin
                cmd.fclamp = 1'b1;
                state_next = S_EMUL;
            end
            S_EMUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_ELI;
            end
            S_ELI:
            begin
                cmd.li_upd = 1'b1;
                j_next     = j_reg + CNT_W'(1);
                state_next = S_EJ;
            end
            S_TRD:
            begin
                cmd.rd     = 1'b1;
                state_next = S_TMUL;
            end
            S_TMUL:
            begin
                cmd.mul      = 1'b1;
                cmd.mul_term = 1'b1;
                state_next   = S_TACC;
            end
            S_TACC:
            begin
                cmd.acc = 1'b1;
                if (i_reg + CNT_W'(1) < sts.count)
                begin
                    i_next     = i_reg + CNT_W'(1);
                    state_next = S_EI;
                end
                else
                    state_next = S_FIN;
            end
            S_FIN:
            begin
                cmd.fin    = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                // hand over once the output register is free
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else
            out_valid_next = out_valid_reg && out_stall;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            i_reg         <= '0;
            j_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

/* sim/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for lagrange_interpolation_eval: a directed table of
// point writes, evaluates and register writes, a fill of every slot, then
// random point-set phases with noise, scored by table or a Q16.16 predictor
// ----------------------------------------------------------------------------
module tb_top;
    import lie_pkg::*;

    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_EVAL  = 1'b1;
    localparam int   NPTS       = 16;
    localparam longint ONE_Q    = 65536;

    typedef struct packed {
        logic signed [31:0] value;
        logic [1:0]         status;
    } result_t;

    typedef struct {
        bit                 is_cfg;
        logic [1:0]         cidx;
        logic [4:0]         cdata;
        logic               mode;
        logic [3:0]         idx;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic signed [31:0] q;
        bit                 typed;
        logic signed [31:0] ev;
        logic [1:0]         es;
    } row_t;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [1:0]         cfg_index;
    logic [4:0]         cfg_data;
    logic               in_valid;
    logic               in_stall;
    logic               mode;
    logic [3:0]         point_index;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic signed [31:0] coord_z;
    logic signed [31:0] query;
    logic               out_valid;
    logic               out_stall;
    logic signed [31:0] value;
    logic [1:0]         status;

    // predictor state
    logic signed [31:0] pt_x [NPTS];
    logic signed [31:0] pt_y [NPTS];
    logic signed [31:0] pt_z [NPTS];
    logic [1:0]         dom_reg;
    logic [1:0]         cod_reg;
    logic [4:0]         cnt_reg;

    result_t            pending_results[$];
    int                 err_count;
    bit                 quiet;
    int                 stall_left;
    row_t               dir_rows[$];

    lagrange_interpolation_eval DUT
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .mode        (mode),
        .point_index (point_index),
        .coord_x     (coord_x),
        .coord_y     (coord_y),
        .coord_z     (coord_z),
        .query       (query),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .value       (value),
        .status      (status)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #100_000_000;
        $display("tb_top: errors");
        $finish;
    end

    function automatic logic [1:0] axis_map(input logic [1:0] code);
        return (code == 2'd3) ? 2'd2 : code;
    endfunction

    function automatic longint coord_of(input logic [1:0] axis, input int slot);
        if (axis == AXIS_X)
            return longint'(pt_x[slot]);
        else if (axis == AXIS_Y)
            return longint'(pt_y[slot]);
        return longint'(pt_z[slot]);
    endfunction

    function automatic longint clip32(input longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    // updates point store on writes, computes the interpolation on evaluates
    function automatic result_t interpolate(input logic m, input logic [3:0] idx,
                                            input logic signed [31:0] x,
                                            input logic signed [31:0] y,
                                            input logic signed [31:0] z,
                                            input logic signed [31:0] q);
        result_t r;
        logic [1:0] d;
        logic [1:0] c;
        int n;
        bit dup;
        bit sat;
        longint sum;
        longint li;
        longint f;
        longint t;
        longint qq;
        r.value = 32'sd0;
        r.status = ST_OK;
        if (m == MODE_WRITE)
        begin
            pt_x[idx] = x;
            pt_y[idx] = y;
            pt_z[idx] = z;
            return r;
        end
        d = axis_map(dom_reg);
        c = axis_map(cod_reg);
        n = (cnt_reg > NPTS) ? NPTS : int'(cnt_reg);
        qq = longint'(q);
        if (d == c)
        begin
            r.status = ST_AXES;
            return r;
        end
        dup = 1'b0;
        for (int i = 0; i < n; i++)
            for (int j = i + 1; j < n; j++)
                if (coord_of(d, i) == coord_of(d, j))
                    dup = 1'b1;
        if (dup)
        begin
            r.status = ST_DUP;
            return r;
        end
        sat = 1'b0;
        sum = 0;
        for (int i = 0; i < n; i++)
        begin
            li = ONE_Q;
            for (int j = 0; j < n; j++)
            begin
                if (j != i)
                begin
                    t = ((qq - coord_of(d, j)) * ONE_Q) / (coord_of(d, i) - coord_of(d, j));
                    f = clip32(t);
                    if (f != t)
                        sat = 1'b1;
                    t = (li * f) / ONE_Q;
                    li = clip32(t);
                    if (li != t)
                        sat = 1'b1;
                end
            end
            sum += (coord_of(c, i) * li) / ONE_Q;
        end
        t = clip32(sum);
        if (t != sum)
            sat = 1'b1;
        r.value = t[31:0];
        if (sat)
            r.status = ST_SAT;
        return r;
    endfunction

    // receiver: random stall bursts
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end
        else if (stall_left > 0)
        begin
            out_stall  <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else if (!quiet && $urandom_range(0, 5) == 0)
        begin
            out_stall  <= 1'b1;
            stall_left <= $urandom_range(0, 10);
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    // result checker
    always @(posedge clk)
    begin
        result_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result transaction value=%0d status=%0d", value, status);
                err_count++;
            end
            else
            begin
                e = pending_results.pop_front();
                if (value !== e.value)
                begin
                    $error("value: expected %0d actual %0d", e.value, value);
                    err_count++;
                end
                if (status !== e.status)
                begin
                    $error("status: expected %0d actual %0d", e.status, status);
                    err_count++;
                end
            end
        end
    end

    task automatic send_item(input logic m, input logic [3:0] idx,
                             input logic signed [31:0] x, input logic signed [31:0] y,
                             input logic signed [31:0] z, input logic signed [31:0] q,
                             input bit typed, input result_t typed_res);
        result_t r;
        mode        <= m;
        point_index <= idx;
        coord_x     <= x;
        coord_y     <= y;
        coord_z     <= z;
        query       <= q;
        in_valid    <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        r = interpolate(m, idx, x, y, z, q);
        pending_results.push_back(typed ? typed_res : r);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
    endtask

    // sender holds off until the block has delivered everything
    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [4:0] data);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (idx == CFG_DOMAIN)
            dom_reg = data[1:0];
        else if (idx == CFG_CODOMAIN)
            cod_reg = data[1:0];
        else if (idx == CFG_COUNT)
            cnt_reg = data;
    endtask

    function automatic row_t wr_row(input logic [3:0] idx, input logic signed [31:0] x,
                                    input logic signed [31:0] y,
                                    input logic signed [31:0] z);
        row_t r;
        r = '{default: '0};
        r.mode = MODE_WRITE;
        r.idx = idx;
        r.x = x;
        r.y = y;
        r.z = z;
        r.typed = 1'b1;
        r.es = ST_OK;
        return r;
    endfunction

    function automatic row_t ev_row(input logic signed [31:0] q, input bit typed,
                                    input logic signed [31:0] ev, input logic [1:0] es);
        row_t r;
        r = '{default: '0};
        r.mode = MODE_EVAL;
        r.q = q;
        r.typed = typed;
        r.ev = ev;
        r.es = es;
        return r;
    endfunction

    function automatic row_t cfg_row(input logic [1:0] idx, input logic [4:0] data);
        row_t r;
        r = '{default: '0};
        r.is_cfg = 1'b1;
        r.cidx = idx;
        r.cdata = data;
        return r;
    endfunction

    // small signed Q16.16 value, about +-8.0
    function automatic logic signed [31:0] small_q();
        return $signed($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000;
    endfunction

    initial
    begin
        const logic signed [31:0] QMAX = 32'sh7FFF_FFFF;
        const logic signed [31:0] QMIN = 32'sh8000_0000;
        result_t tr;
        row_t rw;
        int n;
        int span;
        int kind;
        int slot;
        logic [1:0] d;
        logic signed [31:0] c [3];
        logic signed [31:0] q;

        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        mode = MODE_WRITE;
        point_index = '0;
        coord_x = '0;
        coord_y = '0;
        coord_z = '0;
        query = '0;
        err_count = 0;
        quiet = 1'b0;
        dom_reg = AXIS_X;
        cod_reg = AXIS_Y;
        cnt_reg = 5'd1;
        for (int k = 0; k < NPTS; k++)
        begin
            pt_x[k] = '0;
            pt_y[k] = '0;
            pt_z[k] = '0;
        end
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        dir_rows.push_back(wr_row(4'd0, 32'sd0, 32'sh0001_0000, QMAX));
        // one point with reset count: value is its ordinate
        dir_rows.push_back(ev_row(32'sh0003_0000, 1'b1, 32'sh0001_0000, ST_OK));
        dir_rows.push_back(ev_row(QMAX, 1'b1, 32'sh0001_0000, ST_OK));
        dir_rows.push_back(wr_row(4'd1, 32'sh0001_0000, 32'sh0002_0000, QMIN));
        dir_rows.push_back(cfg_row(CFG_COUNT, 5'd2));
        dir_rows.push_back(ev_row(32'sh0002_0000, 1'b0, '0, ST_OK));
        dir_rows.push_back(ev_row(QMIN, 1'b0, '0, ST_OK));
        dir_rows.push_back(ev_row(QMAX, 1'b0, '0, ST_OK));
        dir_rows.push_back(cfg_row(CFG_CODOMAIN, 5'd0));
        dir_rows.push_back(ev_row(32'sd5, 1'b1, 32'sd0, ST_AXES));
        // axis code three behaves as z
        dir_rows.push_back(cfg_row(CFG_DOMAIN, 5'd3));
        dir_rows.push_back(cfg_row(CFG_CODOMAIN, 5'd2));
        dir_rows.push_back(ev_row(32'sd0, 1'b1, 32'sd0, ST_AXES));
        dir_rows.push_back(cfg_row(CFG_DOMAIN, 5'd1));
        dir_rows.push_back(ev_row(QMIN, 1'b0, '0, ST_OK));
        dir_rows.push_back(ev_row(32'sh0001_8000, 1'b0, '0, ST_OK));
        // duplicate abscissa on y
        dir_rows.push_back(wr_row(4'd1, QMAX, 32'sh0001_0000, QMIN));
        dir_rows.push_back(ev_row(32'sd0, 1'b1, 32'sd0, ST_DUP));
        dir_rows.push_back(wr_row(4'd15, QMIN, QMAX, 32'sh5555_AAAA));
        dir_rows.push_back(cfg_row(CFG_COUNT, 5'd0));
        dir_rows.push_back(ev_row(QMAX, 1'b1, 32'sd0, ST_OK));

        foreach (dir_rows[k])
        begin
            rw = dir_rows[k];
            if (rw.is_cfg)
                write_reg(rw.cidx, rw.cdata);
            else
            begin
                tr.value = rw.ev;
                tr.status = rw.es;
                send_item(rw.mode, rw.idx, rw.x, rw.y, rw.z, rw.q, rw.typed, tr);
            end
        end

        // fill every slot so any count reads written points only
        tr = '0;
        for (int k = 0; k < NPTS; k++)
            send_item(MODE_WRITE, k[3:0], $urandom(), $urandom(), $urandom(), $urandom(),
                      1'b0, tr);

        for (int ph = 0; ph < 8; ph++)
        begin
            write_reg(CFG_DOMAIN, 5'($urandom_range(0, 3)));
            // mostly distinct axes, now and then equal
            if ($urandom_range(0, 4) == 0)
                write_reg(CFG_CODOMAIN, {3'b0, dom_reg});
            else
                write_reg(CFG_CODOMAIN, 5'((axis_map(dom_reg) + $urandom_range(1, 2)) % 3));
            if (ph == 5)
                n = 16;
            else if (ph == 6)
                n = 31;
            else if (ph == 2)
                n = 1;
            else
                n = $urandom_range(2, 6);
            write_reg(CFG_COUNT, 5'(n));
            if (n > NPTS)
                n = NPTS;
            span = (n > 0) ? n : 1;
            d = axis_map(dom_reg);
            quiet = (ph == 7);
            if (ph == 7)
                drain_results();
            for (int it = 0; it < 45; it++)
            begin
                if (it < span || $urandom_range(0, 9) < ((n > 8) ? 9 : 5))
                begin
                    slot = (it < span) ? it : $urandom_range(0, span - 1);
                    if ($urandom_range(0, 5) == 0)
                        slot = $urandom_range(0, 15);
                    kind = $urandom_range(0, 19);
                    c[0] = small_q();
                    c[1] = small_q();
                    c[2] = small_q();
                    if (kind < 14)
                        c[d] = (slot - span / 2) * 65536 + $urandom_range(0, 32'h3FFF);
                    else if (kind < 17)
                    begin
                        c[0] = $urandom();
                        c[1] = $urandom();
                        c[2] = $urandom();
                    end
                    else if (kind < 19)
                        c[d] = 32'(coord_of(d, $urandom_range(0, span - 1)));
                    else
                    begin
                        c[0] = $urandom_range(0, 1) ? QMAX : QMIN;
                        c[1] = $urandom_range(0, 1) ? QMAX : QMIN;
                        c[2] = $urandom_range(0, 1) ? QMAX : QMIN;
                    end
                    send_item(MODE_WRITE, slot[3:0], c[0], c[1], c[2], $urandom(),
                              1'b0, tr);
                end
                else
                begin
                    if ($urandom_range(0, 4) == 0)
                        q = $urandom();
                    else
                        q = $signed($urandom_range(0, span * 65536)) - (span / 2) * 65536;
                    send_item(MODE_EVAL, 4'($urandom()), $urandom(), $urandom(), $urandom(),
                              q, 1'b0, tr);
                end
            end
        end

        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (err_count == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule
